@@ sv/radix2_fft_engine_unit_defines.svh @@
// Assertion helpers shared by the RTL.
`ifndef RADIX2_FFT_ENGINE_UNIT_DEFINES_SVH
`define RADIX2_FFT_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define R2FFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define R2FFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/r2fft_pkg.sv @@
package r2fft_pkg;

  localparam int WORK_BITS = 26;
  localparam int IDX_BITS  = 10;
  localparam int OUT_W     = 64;
  localparam int CFG_AW    = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_NOT_READY = 1'b1;

  localparam logic [CFG_AW-1:0] REG_LOG2_ADDR = 3'd0;
  localparam logic [CFG_AW-1:0] REG_INV_ADDR  = 3'd4;
  localparam logic [3:0]        LOG2_RESET    = 4'd10;

  localparam int     QFRAC  = 28;
  localparam longint PI_Q28 = 64'sd843314857;

  // Shift-subtract quotient of two nonnegative operands
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & longint'(1));
      if (r >= den) begin
        r = r - den;
        q = q | (longint'(1) <<< b);
      end
    end
    return q;
  endfunction

  // Q28 Taylor series of sin or cos for x in [0, pi/2]
  function automatic longint series(longint x, bit want_sin);
    longint x2;
    longint term;
    longint sum;
    longint d;
    x2   = (x * x) >>> QFRAC;
    term = want_sin ? x : (longint'(1) <<< QFRAC);
    sum  = term;
    for (int k = 1; k <= 14; k++) begin
      d    = want_sin ? longint'((2 * k) * (2 * k + 1)) : longint'((2 * k - 1) * (2 * k));
      term = udiv((term * x2) >>> QFRAC, d);
      sum  = ((k & 1) == 1) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  // Round Q28 to Q1.(twb-1) and clamp to the symmetric range
  function automatic longint to_twiddle(longint q, int twb);
    int     sh;
    longint lim;
    longint v;
    sh  = QFRAC - (twb - 1);
    lim = (longint'(1) <<< (twb - 1)) - 1;
    v   = (q + (longint'(1) <<< (sh - 1))) >>> sh;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  // Twiddle table entry m of a 2^lg point table
  function automatic longint tw_entry(int m, int lg, int twb, bit want_sin);
    longint mx;
    bit     upper;
    longint mm;
    longint x;
    longint v;
    mx    = longint'(1) <<< lg;
    upper = (4 * longint'(m)) > mx;
    mm    = upper ? ((mx >>> 1) - m) : longint'(m);
    x     = (2 * PI_Q28 * mm) >>> lg;
    v     = to_twiddle(series(x, want_sin), twb);
    if (!want_sin && upper) v = -v;
    return v;
  endfunction

endpackage

@@ sv/r2fft_mem.sv @@
module r2fft_mem #(
  parameter int AW = 10,
  parameter int DW = 52
) (
  input  logic          clk,
  input  logic          re_a,
  input  logic [AW-1:0] addr_a,
  output logic [DW-1:0] rdata_a_r,
  input  logic          re_b,
  input  logic [AW-1:0] addr_b,
  output logic [DW-1:0] rdata_b_r,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [1<<AW];

  // One write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports, held when idle
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a_r <= mem[addr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem[addr_b];
    end
  end

endmodule

@@ sv/r2fft_twrom.sv @@
module r2fft_twrom #(
  parameter int MAX_POINTS   = 1024,
  parameter int TWIDDLE_BITS = 16,
  parameter int TA           = 9
) (
  input  logic                           clk,
  input  logic                           re,
  input  logic [TA-1:0]                  addr,
  output logic signed [TWIDDLE_BITS-1:0] cos_r,
  output logic signed [TWIDDLE_BITS-1:0] sin_r
);
  import r2fft_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS + 1) - 1;
  localparam int HALF = MAX_POINTS / 2;

  logic signed [TWIDDLE_BITS-1:0] cos_tab [HALF];
  logic signed [TWIDDLE_BITS-1:0] sin_tab [HALF];

  // Build the quarter-wave derived table at elaboration
  for (genvar g = 0; g < HALF; g++) begin : g_tab
    localparam longint CV = tw_entry(g, AW, TWIDDLE_BITS, 1'b0);
    localparam longint SV = tw_entry(g, AW, TWIDDLE_BITS, 1'b1);
    assign cos_tab[g] = TWIDDLE_BITS'(CV);
    assign sin_tab[g] = TWIDDLE_BITS'(SV);
  end

  // Registered lookup
  always_ff @(posedge clk) begin
    if (re) begin
      cos_r <= cos_tab[addr];
      sin_r <= sin_tab[addr];
    end
  end

endmodule

@@ sv/radix2_fft_engine_unit.sv @@
// In-place radix-2 DIT FFT over N = 2^k complex points (k from log2_points, clamped to
// 1..log2 MAX_POINTS). Send opcode 0 transfers to load samples; the Nth load starts the
// transform and in_tready stays low until it ends. The transform runs on one point memory
// with two read ports and one write port and one butterfly unit: a bit-reversal pass that
// swaps points with reversed partners, then k stages of N/2 butterflies, each read,
// multiplied, summed and written to its difference point, then its sum point, then, in
// inverse mode, a scaling pass that rewrites each point. A read (opcode 1) returns one bin
// through the memory read register and S_RDOUT, or a status 1 result in the cycle after it
// when no frame is ready. A load while bins remain unread drops them. Point memory has no reset.
module radix2_fft_engine_unit #(
  parameter int MAX_POINTS   = 1024,
  parameter int SAMPLE_BITS  = 16,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // bits: sample_real, sample_imag, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // bits: opcode
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // bits: bin_real, bin_imag, bin_index, zero pad
  output logic [r2fft_pkg::OUT_W-1:0]    out_tdata,
  // last_bin
  output logic                           out_tlast,
  // bits: status
  output logic                           out_tuser,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [r2fft_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import r2fft_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS + 1) - 1;
  localparam int KW  = $clog2(AW + 1);
  localparam int TA  = (AW > 1) ? AW - 1 : 1;
  localparam int WB  = WORK_BITS;
  localparam int DW  = 2 * WB;
  localparam int PW  = WB + TWIDDLE_BITS;
  localparam int SB  = SAMPLE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RDOUT,
    S_BR_RD, S_BR_W1, S_BR_W2,
    S_BF_RD, S_BF_MUL, S_BF_SUM, S_BF_WLO, S_BF_WHI,
    S_PS_RD, S_PS_W
  } state_t;

  state_t                  state_r, state_nxt;
  logic [3:0]              log2_r;
  logic                    inv_cfg_r;
  logic [AW-1:0]           load_cnt_r, load_cnt_nxt;
  logic [AW-1:0]           read_cnt_r, read_cnt_nxt;
  logic                    rdy_r, rdy_nxt;
  logic [KW-1:0]           kk_r, kk_nxt;
  logic                    inv_r, inv_nxt;
  logic [AW-1:0]           cnt_r, cnt_nxt;
  logic [KW-1:0]           stage_r, stage_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [WB-1:0]           out_re_r, out_re_nxt;
  logic [WB-1:0]           out_im_r, out_im_nxt;
  logic [IDX_BITS-1:0]     out_idx_r, out_idx_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_st_r, out_st_nxt;
  logic signed [PW-1:0]    p_rc_r, p_is_r, p_rs_r, p_ic_r;
  logic signed [WB-1:0]    tr_r, ti_r;

  logic                    mem_re_a, mem_re_b, mem_we;
  logic [AW-1:0]           mem_addr_a, mem_addr_b, mem_waddr;
  logic [DW-1:0]           mem_wdata, rd_a, rd_b;
  logic                    tw_re;
  logic [TA-1:0]           tw_addr;
  logic signed [TWIDDLE_BITS-1:0] tw_cos, tw_sin;

  logic                    in_acc, cfg_wr;
  logic [KW-1:0]           eff_k;
  logic [AW:0]             n_cur, n_t, load_sum;
  logic                    rd_last;
  logic [AW-1:0]           rev_full, rev_i;
  logic [AW-1:0]           bf_j, bf_i, bf_lo;
  logic [KW-1:0]           tw_sh;
  logic signed [WB-1:0]    a_re, a_im, b_re, b_im, neg_a_im;
  logic signed [PW:0]      sum_r, sum_i;
  logic [DW-1:0]           cj_a, cj_b;
  logic                    last_pt, last_bf;

  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r    <= LOG2_RESET;
      inv_cfg_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr == REG_LOG2_ADDR) log2_r <= cfg_pwdata[3:0];
      if (cfg_paddr == REG_INV_ADDR) inv_cfg_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == REG_LOG2_ADDR) cfg_prdata = {28'd0, log2_r};
    else if (cfg_paddr == REG_INV_ADDR) cfg_prdata = {31'd0, inv_cfg_r};
  end

  // Clamp the size exponent
  always_comb begin
    if (log2_r == 4'd0) eff_k = KW'(1);
    else if (int'(log2_r) > AW) eff_k = KW'(AW);
    else eff_k = KW'(log2_r);
  end

  assign n_cur    = (AW+1)'(1) << eff_k;
  assign n_t      = (AW+1)'(1) << kk_r;
  assign load_sum = {1'b0, load_cnt_r} + (AW+1)'(1);
  assign rd_last  = ({1'b0, read_cnt_r} + (AW+1)'(1)) >= n_cur;

  // Bit reversal of cnt over kk bits
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = cnt_r[AW-1-b];
    end
  end
  assign rev_i = rev_full >> (KW'(AW) - kk_r);

  // Butterfly addressing: insert a zero at bit stage-1 of the butterfly count
  assign bf_j    = cnt_r & ((AW'(1) << (stage_r - KW'(1))) - AW'(1));
  assign bf_i    = ((cnt_r >> (stage_r - KW'(1))) << stage_r) | bf_j;
  assign bf_lo   = bf_i | (AW'(1) << (stage_r - KW'(1)));
  assign tw_sh   = KW'(AW) - stage_r;
  assign tw_addr = TA'(bf_j << tw_sh);

  assign last_pt = ({1'b0, cnt_r} == n_t - (AW+1)'(1));
  assign last_bf = ({1'b0, cnt_r} == (n_t >> 1) - (AW+1)'(1));

  // Operand views
  assign a_re     = rd_a[WB-1:0];
  assign a_im     = rd_a[DW-1:WB];
  assign b_re     = rd_b[WB-1:0];
  assign b_im     = rd_b[DW-1:WB];
  assign neg_a_im = -a_im;
  assign cj_a     = inv_r ? {neg_a_im, a_re} : rd_a;
  assign cj_b     = inv_r ? {WB'(-b_im), b_re} : rd_b;
  assign sum_r    = {p_rc_r[PW-1], p_rc_r} + {p_is_r[PW-1], p_is_r};
  assign sum_i    = {p_ic_r[PW-1], p_ic_r} - {p_rs_r[PW-1], p_rs_r};

  // Butterfly multiply and sum stages
  always_ff @(posedge clk) begin
    if (state_r == S_BF_MUL) begin
      p_rc_r <= PW'(b_re * tw_cos);
      p_is_r <= PW'(b_im * tw_sin);
      p_rs_r <= PW'(b_re * tw_sin);
      p_ic_r <= PW'(b_im * tw_cos);
    end
    if (state_r == S_BF_SUM) begin
      tr_r <= WB'(sum_r >>> (TWIDDLE_BITS - 1));
      ti_r <= WB'(sum_i >>> (TWIDDLE_BITS - 1));
    end
  end

  // Sequencer next state and memory port control
  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    read_cnt_nxt  = read_cnt_r;
    rdy_nxt       = rdy_r;
    kk_nxt        = kk_r;
    inv_nxt       = inv_r;
    cnt_nxt       = cnt_r;
    stage_nxt     = stage_r;
    out_valid_nxt = out_valid_r;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_st_nxt    = out_st_r;
    mem_re_a      = 1'b0;
    mem_re_b      = 1'b0;
    mem_we        = 1'b0;
    mem_addr_a    = cnt_r;
    mem_addr_b    = rev_i;
    mem_waddr     = cnt_r;
    mem_wdata     = cj_b;
    tw_re         = 1'b0;

    // Drop a result once it is transferred
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_LOAD) begin
            mem_we    = 1'b1;
            mem_waddr = load_cnt_r;
            mem_wdata = {{(WB-SB){in_tdata[2*SB-1]}}, in_tdata[2*SB-1:SB],
                         {(WB-SB){in_tdata[SB-1]}}, in_tdata[SB-1:0]};
            rdy_nxt   = 1'b0;
            if (load_sum >= n_cur) begin
              load_cnt_nxt = '0;
              kk_nxt       = eff_k;
              inv_nxt      = inv_cfg_r;
              cnt_nxt      = '0;
              state_nxt    = S_BR_RD;
            end else begin
              load_cnt_nxt = load_sum[AW-1:0];
            end
          end else if (!rdy_r) begin
            out_valid_nxt = 1'b1;
            out_re_nxt    = '0;
            out_im_nxt    = '0;
            out_idx_nxt   = '0;
            out_last_nxt  = 1'b0;
            out_st_nxt    = ST_NOT_READY;
          end else begin
            mem_re_a     = 1'b1;
            mem_addr_a   = read_cnt_r;
            out_idx_nxt  = IDX_BITS'(read_cnt_r);
            out_last_nxt = rd_last;
            out_st_nxt   = ST_OK;
            state_nxt    = S_RDOUT;
            if (rd_last) begin
              rdy_nxt      = 1'b0;
              read_cnt_nxt = '0;
            end else begin
              read_cnt_nxt = read_cnt_r + AW'(1);
            end
          end
        end
      end
      S_RDOUT: begin
        out_valid_nxt = 1'b1;
        out_re_nxt    = rd_a[WB-1:0];
        out_im_nxt    = rd_a[DW-1:WB];
        state_nxt     = S_IDLE;
      end
      S_BR_RD: begin
        if ((cnt_r < rev_i) || ((cnt_r == rev_i) && inv_r)) begin
          mem_re_a  = 1'b1;
          mem_re_b  = 1'b1;
          state_nxt = S_BR_W1;
        end else if (last_pt) begin
          cnt_nxt   = '0;
          stage_nxt = KW'(1);
          state_nxt = S_BF_RD;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_BR_W1: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = cj_b;
        if (cnt_r < rev_i) begin
          state_nxt = S_BR_W2;
        end else if (last_pt) begin
          cnt_nxt   = '0;
          stage_nxt = KW'(1);
          state_nxt = S_BF_RD;
        end else begin
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = S_BR_RD;
        end
      end
      S_BR_W2: begin
        mem_we    = 1'b1;
        mem_waddr = rev_i;
        mem_wdata = cj_a;
        if (last_pt) begin
          cnt_nxt   = '0;
          stage_nxt = KW'(1);
          state_nxt = S_BF_RD;
        end else begin
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = S_BR_RD;
        end
      end
      S_BF_RD: begin
        mem_re_a   = 1'b1;
        mem_addr_a = bf_i;
        mem_re_b   = 1'b1;
        mem_addr_b = bf_lo;
        tw_re      = 1'b1;
        state_nxt  = S_BF_MUL;
      end
      S_BF_MUL: state_nxt = S_BF_SUM;
      S_BF_SUM: state_nxt = S_BF_WLO;
      S_BF_WLO: begin
        mem_we    = 1'b1;
        mem_waddr = bf_lo;
        mem_wdata = {WB'(a_im - ti_r), WB'(a_re - tr_r)};
        state_nxt = S_BF_WHI;
      end
      S_BF_WHI: begin
        mem_we    = 1'b1;
        mem_waddr = bf_i;
        mem_wdata = {WB'(a_im + ti_r), WB'(a_re + tr_r)};
        if (!last_bf) begin
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = S_BF_RD;
        end else begin
          cnt_nxt = '0;
          if (stage_r != kk_r) begin
            stage_nxt = stage_r + KW'(1);
            state_nxt = S_BF_RD;
          end else if (inv_r) begin
            state_nxt = S_PS_RD;
          end else begin
            rdy_nxt      = 1'b1;
            read_cnt_nxt = '0;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_PS_RD: begin
        mem_re_a  = 1'b1;
        state_nxt = S_PS_W;
      end
      S_PS_W: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = {WB'(neg_a_im >>> kk_r), WB'(a_re >>> kk_r)};
        if (last_pt) begin
          cnt_nxt      = '0;
          rdy_nxt      = 1'b1;
          read_cnt_nxt = '0;
          state_nxt    = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = S_PS_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_cnt_r  <= '0;
      read_cnt_r  <= '0;
      rdy_r       <= 1'b0;
      kk_r        <= KW'(1);
      inv_r       <= 1'b0;
      cnt_r       <= '0;
      stage_r     <= KW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      read_cnt_r  <= read_cnt_nxt;
      rdy_r       <= rdy_nxt;
      kk_r        <= kk_nxt;
      inv_r       <= inv_nxt;
      cnt_r       <= cnt_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_re_r   <= out_re_nxt;
    out_im_r   <= out_im_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - 2*WB - IDX_BITS){1'b0}}, out_idx_r, out_im_r, out_re_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_st_r;

  r2fft_mem #(
    .AW (AW),
    .DW (DW)
  ) u_mem (
    .clk       (clk),
    .re_a      (mem_re_a),
    .addr_a    (mem_addr_a),
    .rdata_a_r (rd_a),
    .re_b      (mem_re_b),
    .addr_b    (mem_addr_b),
    .rdata_b_r (rd_b),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata)
  );

  r2fft_twrom #(
    .MAX_POINTS   (MAX_POINTS),
    .TWIDDLE_BITS (TWIDDLE_BITS),
    .TA           (TA)
  ) u_twrom (
    .clk   (clk),
    .re    (tw_re),
    .addr  (tw_addr),
    .cos_r (tw_cos),
    .sin_r (tw_sin)
  );

`include "radix2_fft_engine_unit_defines.svh"

  `R2FFT_ASSERT_NXT(a_load_drops_frame, in_acc && (in_tuser == OP_LOAD), !rdy_r, "load left frame ready")
  `R2FFT_ASSERT_IMP(a_ready_no_partial, rdy_r, load_cnt_r == '0, "ready frame with partial load")
  `R2FFT_ASSERT_NXT(a_rdout_result, state_r == S_RDOUT, out_tvalid && (out_tuser == ST_OK), "bin read lost")

endmodule
